>>> rtl/core/assert_macros.svh
// Assertion macros shared by the containment filter RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk_i.
`define ACF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequence checked in the cycle after the trigger.
`define ACF_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/acf_pkg.sv
// Package for the alignment containment filter: fixed field widths, command codes
// and the controller/datapath handshake structs. No dependencies.
`timescale 1ns / 1ps

package acf_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned QIDX_W = 16;
  localparam int unsigned SIDX_W = 24;
  localparam int unsigned TAG_W  = 4;
  localparam int unsigned BAND_W = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEED   = 2'd2;

  typedef struct packed {
    logic load;
    logic prep;
    logic scan_rd;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic table_empty;
    logic out_free;
  } ctl_sts_t;

endpackage

>>> rtl/core/acf_controller.sv
// Sequencing FSM for the containment filter: accept, prepare, scan, drain, commit.
// Depends on acf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module acf_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output acf_pkg::ctl_cmd_t cmd_o,
  input  acf_pkg::ctl_sts_t sts_i
);
  import acf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_tvalid_i && ready_q) begin
            state_q <= S_PREP;
            ready_q <= 1'b0;
          end
        end
        S_PREP: begin
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (sts_i.table_empty || sts_i.scan_last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign s_tready_o    = ready_q;
  assign cmd_o.load    = s_tvalid_i && ready_q;
  assign cmd_o.prep    = (state_q == S_PREP);
  assign cmd_o.scan_rd = (state_q == S_SCAN) && !sts_i.table_empty;
  assign cmd_o.commit  = (state_q == S_DONE) && sts_i.out_free;

  `ACF_ASSERT(a_ready_only_idle, !ready_q || (state_q == S_IDLE), "ready outside idle")
  `ACF_ASSERT_NEXT(a_accept_to_prep, (s_tvalid_i && ready_q), (state_q == S_PREP),
                   "accepted transfer did not start preparation")
  `ACF_ASSERT_NEXT(a_commit_to_idle, cmd_o.commit, (ready_q && (state_q == S_IDLE)),
                   "commit did not return to idle")

endmodule

>>> rtl/core/acf_datapath.sv
// Datapath for the containment filter: item registers, seed band box, entry memory,
// scan compare, fill count and result register. Depends on acf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module acf_datapath #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned COORD_BITS  = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [acf_pkg::BAND_W-1:0]             cfg_wdata_i,
  input  logic [acf_pkg::CMD_W-1:0]              command_i,
  input  logic [acf_pkg::QIDX_W-1:0]             query_index_i,
  input  logic [acf_pkg::SIDX_W-1:0]             subject_index_i,
  input  logic [acf_pkg::TAG_W-1:0]              subject_db_tag_i,
  input  logic [acf_pkg::TAG_W-1:0]              query_db_tag_i,
  input  logic [COORD_BITS-1:0]                  subject_start_i,
  input  logic [COORD_BITS-1:0]                  subject_end_i,
  input  logic [COORD_BITS-1:0]                  query_start_i,
  input  logic [COORD_BITS-1:0]                  query_end_i,
  input  logic [COORD_BITS-1:0]                  subject_length_i,
  input  logic [COORD_BITS-1:0]                  query_length_i,
  input  acf_pkg::ctl_cmd_t                      cmd_i,
  output acf_pkg::ctl_sts_t                      sts_o,
  output logic                                   m_tvalid_o,
  input  logic                                   m_tready_i,
  output logic                                   found_o,
  output logic                                   stored_o,
  output logic                                   table_full_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]       alignment_count_o
);
  import acf_pkg::*;

  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned SUM_W   = ((COORD_BITS > BAND_W) ? COORD_BITS : BAND_W) + 1;
  localparam int unsigned ENTRY_W = QIDX_W + SIDX_W + 2 * TAG_W + 4 * COORD_BITS;

  // band edge: low end clamped to zero, high end clamped to length-1
  function automatic logic [COORD_BITS-1:0] band_lo(input logic [COORD_BITS-1:0] off,
                                                    input logic [BAND_W-1:0] band);
    logic [SUM_W-1:0] o;
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] r;
    o = SUM_W'(off);
    b = SUM_W'(band);
    r = (o >= b) ? (o - b) : '0;
    return r[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] band_hi(input logic [COORD_BITS-1:0] off,
                                                    input logic [BAND_W-1:0] band,
                                                    input logic [COORD_BITS-1:0] len);
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] l;
    logic [SUM_W-1:0] r;
    s = SUM_W'(off) + SUM_W'(band);
    l = (len == '0) ? SUM_W'(1) : SUM_W'(len);
    r = (s < l) ? s : (l - SUM_W'(1));
    return r[COORD_BITS-1:0];
  endfunction

  logic [BAND_W-1:0]     band_q;
  logic [CMD_W-1:0]      cmd_q;
  logic [QIDX_W-1:0]     qidx_q;
  logic [SIDX_W-1:0]     sidx_q;
  logic [TAG_W-1:0]      stag_q;
  logic [TAG_W-1:0]      qtag_q;
  logic [COORD_BITS-1:0] s_lo_q, s_hi_q, q_lo_q, q_hi_q, s_len_q, q_len_q;

  logic [ENTRY_W-1:0]    mem_q [TABLE_DEPTH];
  logic [ENTRY_W-1:0]    rd_data_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      idx_q;
  logic [CNT_W-1:0]      fill_q;
  logic                  hit_q;

  logic                  out_vld_q, found_q, stored_q, full_q;
  logic [CNT_W-1:0]      count_q;

  logic [QIDX_W-1:0]     e_qidx;
  logic [SIDX_W-1:0]     e_sidx;
  logic [2*TAG_W-1:0]    e_tags;
  logic [COORD_BITS-1:0] e_slo, e_shi, e_qlo, e_qhi;
  logic                  is_seed, cmd_known, match;
  logic                  tbl_full, insert_ok;
  logic [ENTRY_W-1:0]    wr_entry;

  assign {e_qidx, e_sidx, e_tags, e_slo, e_shi, e_qlo, e_qhi} = rd_data_q;

  assign is_seed   = (cmd_q == CMD_SEED);
  assign cmd_known = (cmd_q == CMD_INSERT) || (cmd_q == CMD_CHECK) || is_seed;
  assign match     = cmd_known && (e_qidx == qidx_q) && (e_sidx == sidx_q) &&
                     (is_seed || (e_tags == {stag_q, qtag_q})) &&
                     (s_lo_q >= e_slo) && (s_hi_q <= e_shi) &&
                     (q_lo_q >= e_qlo) && (q_hi_q <= e_qhi);

  assign tbl_full  = (fill_q == CNT_W'(TABLE_DEPTH));
  assign insert_ok = (cmd_q == CMD_INSERT) && !hit_q && !tbl_full;
  assign wr_entry  = {qidx_q, sidx_q, stag_q, qtag_q, s_lo_q, s_hi_q, q_lo_q, q_hi_q};

  assign sts_o.scan_last   = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);
  assign sts_o.table_empty = (fill_q == '0);
  assign sts_o.out_free    = !out_vld_q || m_tready_i;

  // item and box registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= command_i;
      qidx_q  <= query_index_i;
      sidx_q  <= subject_index_i;
      stag_q  <= subject_db_tag_i;
      qtag_q  <= query_db_tag_i;
      s_lo_q  <= subject_start_i;
      s_hi_q  <= subject_end_i;
      q_lo_q  <= query_start_i;
      q_hi_q  <= query_end_i;
      s_len_q <= subject_length_i;
      q_len_q <= query_length_i;
    end else if (cmd_i.prep && is_seed) begin
      s_lo_q <= band_lo(s_lo_q, band_q);
      s_hi_q <= band_hi(s_lo_q, band_q, s_len_q);
      q_lo_q <= band_lo(q_lo_q, band_q);
      q_hi_q <= band_hi(q_lo_q, band_q, q_len_q);
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && insert_ok) begin
      mem_q[fill_q[IDX_W-1:0]] <= wr_entry;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q    <= '0;
      rd_vld_q  <= 1'b0;
      idx_q     <= '0;
      fill_q    <= '0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
      found_q   <= 1'b0;
      stored_q  <= 1'b0;
      full_q    <= 1'b0;
      count_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        band_q <= cfg_wdata_i;
      end
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.prep) begin
        idx_q <= '0;
      end else if (cmd_i.scan_rd) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.prep) begin
        hit_q <= 1'b0;
      end else if (rd_vld_q && match) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_vld_q <= 1'b1;
        found_q   <= hit_q;
        stored_q  <= insert_ok;
        full_q    <= (cmd_q == CMD_INSERT) && !hit_q && tbl_full;
        count_q   <= insert_ok ? (fill_q + 1'b1) : fill_q;
        if (insert_ok) begin
          fill_q <= fill_q + 1'b1;
        end
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o        = out_vld_q;
  assign found_o           = found_q;
  assign stored_o          = stored_q;
  assign table_full_o      = full_q;
  assign alignment_count_o = count_q;

  `ACF_ASSERT(a_fill_bound, fill_q <= CNT_W'(TABLE_DEPTH), "fill count beyond table depth")
  `ACF_ASSERT(a_fill_step, $stable(fill_q) || (fill_q == ($past(fill_q) + 1'b1)),
              "fill count moved by other than one")
  `ACF_ASSERT_NEXT(a_commit_valid, cmd_i.commit, m_tvalid_o,
                   "committed result not presented")

endmodule

>>> rtl/core/alignment_containment_filter_top.sv
// Alignment containment filter: one item in flight, scanned over n stored entries,
// n being the entries held. Each item goes through prepare, scan, drain and done;
// the result goes out on m_axis at commit and the next item is taken after that.
// The single memory read port, one entry per cycle, paces the scan. Reset empties
// the table at once (fill count cleared, no clearing pass) and zeroes band_length.
`timescale 1ns / 1ps

module alignment_containment_filter_top #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned COORD_BITS  = 24
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_we_i,
  input  logic [acf_pkg::BAND_W-1:0]                    cfg_wdata_i,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // command, query_index, subject_index, subject_db_tag, query_db_tag, subject_start,
  // subject_end, query_start, query_end, subject_length, query_length, zero pad
  input  logic [((50 + 6 * COORD_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // found, stored, table_full, alignment_count, zero pad
  output logic [((3 + $clog2(TABLE_DEPTH+1) + 7) / 8) * 8-1:0] m_axis_tdata
);
  import acf_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned OUT_W = ((3 + CNT_W + 7) / 8) * 8;
  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned CO    = CMD_W + QIDX_W + SIDX_W + 2 * TAG_W;

  ctl_cmd_t         ctl_cmd;
  ctl_sts_t         ctl_sts;
  logic             found, stored, table_full;
  logic [CNT_W-1:0] alignment_count;

  acf_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .cmd_o      (ctl_cmd),
    .sts_i      (ctl_sts)
  );

  acf_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .command_i         (s_axis_tdata[0 +: CMD_W]),
    .query_index_i     (s_axis_tdata[CMD_W +: QIDX_W]),
    .subject_index_i   (s_axis_tdata[CMD_W + QIDX_W +: SIDX_W]),
    .subject_db_tag_i  (s_axis_tdata[CMD_W + QIDX_W + SIDX_W +: TAG_W]),
    .query_db_tag_i    (s_axis_tdata[CMD_W + QIDX_W + SIDX_W + TAG_W +: TAG_W]),
    .subject_start_i   (s_axis_tdata[CO +: C]),
    .subject_end_i     (s_axis_tdata[CO + C +: C]),
    .query_start_i     (s_axis_tdata[CO + 2 * C +: C]),
    .query_end_i       (s_axis_tdata[CO + 3 * C +: C]),
    .subject_length_i  (s_axis_tdata[CO + 4 * C +: C]),
    .query_length_i    (s_axis_tdata[CO + 5 * C +: C]),
    .cmd_i             (ctl_cmd),
    .sts_o             (ctl_sts),
    .m_tvalid_o        (m_axis_tvalid),
    .m_tready_i        (m_axis_tready),
    .found_o           (found),
    .stored_o          (stored),
    .table_full_o      (table_full),
    .alignment_count_o (alignment_count)
  );

  assign m_axis_tdata = OUT_W'({alignment_count, table_full, stored, found});

endmodule
